[sv/bpa_pkg.sv]
// buddy page allocator package: command codes and fixed field widths
// no dependencies
`default_nettype none
package bpa_pkg;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned ORD_W = 4;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned CFG_W = 11;
	localparam int unsigned BIG_W = 17;

	typedef logic [ORD_W-1:0] ord_t;
	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ALLOC = 2'd0;
	localparam cmd_t CMD_FREE  = 2'd1;
	localparam cmd_t CMD_ADD   = 2'd2;
	localparam cmd_t CMD_NOP   = 2'd3;
endpackage
`default_nettype wire

[sv/bpa_ram.sv]
// generic single-port ram, registered read
// no dependencies
`default_nettype none
module bpa_ram #(
	parameter int unsigned WIDTH = 27,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire

[sv/buddy_page_allocator.sv]
// buddy page allocator top level: sequencer, list heads and the page link ram
// depends on bpa_pkg and bpa_ram
// one ram access per cycle; a free that merges through every order takes the longest, and
// an allocate scans the order lists upward, unlinks the block found, then splits it round
// by round down to the asked order; a stalled result holds the block until it is taken;
// one item in flight at a time, the next accepted after the result
// reset: after arst_n the ram is cleared page by page, items stalled meanwhile
`default_nettype none
module buddy_page_allocator #(
	parameter int unsigned POOL_PAGES  = 1024,
	parameter int unsigned ORDER_COUNT = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire bpa_pkg::cmd_t              command,
	input  wire logic [bpa_pkg::IDX_W-1:0]  page_index,
	input  wire bpa_pkg::ord_t              block_order,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            status,
	output logic [bpa_pkg::IDX_W-1:0]       result_index,
	output bpa_pkg::ord_t                   result_order,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [bpa_pkg::CFG_W-1:0]  cfg_data
);
	import bpa_pkg::*;

	localparam int unsigned AW  = $clog2(POOL_PAGES);
	localparam int unsigned LW  = $clog2(POOL_PAGES + 1);
	localparam int unsigned HXW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
	localparam int unsigned W   = 2 * LW + 1 + ORD_W;
	localparam logic [LW-1:0]    NULL_LINK = LW'(POOL_PAGES);
	localparam logic [BIG_W-1:0] POOL_B    = BIG_W'(POOL_PAGES);
	localparam logic [AW-1:0]    LAST_PG   = AW'(POOL_PAGES - 1);
	localparam logic [ORD_W:0]   NORD      = (ORD_W+1)'(ORDER_COUNT);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, A_SCAN, A_SPLIT, A_FRD, A_FWR, F_MRD, F_MWR,
		M_CHK, M_RD, M_EV, M_UP, M_ORD, M_OWR,
		UL_RD, UL_GET, UL_PVR, UL_PVW, UL_NXR, UL_NXW, UL_PGR, UL_PGW,
		PU_RD, PU_WR, PU_HR, PU_HW, S_FIN
	} state_t;

	state_t            state_q, ret_q;
	logic [AW-1:0]     clr_q, pg_q, tg_q;
	logic [LW-1:0]     nx_q, pv_q;
	logic [LW-1:0]     head_q [ORDER_COUNT];
	cmd_t              cmd_q;
	ord_t              ord_q, cur_q, lo_q;
	logic              st_q, pmark_q;
	logic [CFG_W-1:0]  pages_q;

	logic [AW-1:0]     ram_addr;
	logic              ram_we;
	logic [W-1:0]      ram_wd, ram_rd;
	logic [LW-1:0]     r_next, r_prev, head_lo;
	logic              r_free;
	ord_t              r_ord, cur_n;
	logic [BIG_W-1:0]  lim, pg_in, b_split, b_merge;

	assign r_next  = ram_rd[W-1 -: LW];
	assign r_prev  = ram_rd[W-1-LW -: LW];
	assign r_free  = ram_rd[ORD_W];
	assign r_ord   = ram_rd[ORD_W-1:0];
	assign head_lo = head_q[lo_q[HXW-1:0]];
	assign cur_n   = cur_q - ORD_W'(1);
	assign lim     = (BIG_W'(pages_q) < POOL_B) ? BIG_W'(pages_q) : POOL_B;
	assign pg_in   = BIG_W'(page_index);
	assign b_split = BIG_W'(pg_q) ^ (BIG_W'(1) << cur_n);
	assign b_merge = BIG_W'(pg_q) ^ (BIG_W'(1) << ord_q);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	bpa_ram #(.WIDTH(W), .DEPTH(POOL_PAGES)) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	always_comb begin
		ram_addr = tg_q;
		ram_we   = 1'b0;
		ram_wd   = ram_rd;
		unique case (state_q)
			S_CLR: begin
				ram_addr = clr_q;
				ram_we   = 1'b1;
				ram_wd   = {NULL_LINK, NULL_LINK, 1'b0, ORD_W'(0)};
			end
			A_FRD, F_MRD, M_ORD: ram_addr = pg_q;
			A_FWR: begin
				ram_addr = pg_q;
				ram_we   = 1'b1;
				ram_wd   = {r_next, r_prev, 1'b0, ord_q};
			end
			F_MWR: begin
				ram_addr = pg_q;
				ram_we   = 1'b1;
				ram_wd   = {r_next, r_prev, 1'b1, ord_q};
			end
			M_OWR: begin
				ram_addr = pg_q;
				ram_we   = 1'b1;
				ram_wd   = {r_next, r_prev, r_free, ord_q};
			end
			UL_PVR: ram_addr = pv_q[AW-1:0];
			UL_PVW: begin
				ram_addr = pv_q[AW-1:0];
				ram_we   = 1'b1;
				ram_wd   = {nx_q, r_prev, r_free, r_ord};
			end
			UL_NXR, PU_HR: ram_addr = nx_q[AW-1:0];
			UL_NXW: begin
				ram_addr = nx_q[AW-1:0];
				ram_we   = 1'b1;
				ram_wd   = {r_next, pv_q, r_free, r_ord};
			end
			UL_PGW: begin
				ram_we = 1'b1;
				ram_wd = {NULL_LINK, NULL_LINK, r_free, r_ord};
			end
			PU_WR: begin
				ram_we = 1'b1;
				ram_wd = pmark_q ? {head_lo, NULL_LINK, 1'b1, lo_q}
				                 : {head_lo, NULL_LINK, r_free, r_ord};
			end
			PU_HW: begin
				ram_addr = nx_q[AW-1:0];
				ram_we   = 1'b1;
				ram_wd   = {r_next, LW'(tg_q), r_free, r_ord};
			end
			default: ram_addr = tg_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ret_q     <= S_FIN;
			clr_q     <= '0;
			pages_q   <= CFG_W'(1024);
			out_valid <= 1'b0;
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_q[i] <= NULL_LINK;
			end
		end else begin
			if (cfg_valid) begin
				pages_q <= cfg_data;
			end
			if (out_valid && !out_stall && state_q != S_FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_PG) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						pg_q    <= pg_in[AW-1:0];
						ord_q   <= block_order;
						cur_q   <= block_order;
						st_q    <= 1'b0;
						state_q <= S_DEC;
						if (command != CMD_ALLOC &&
						    ({1'b0, block_order} >= NORD || pg_in >= POOL_B)) begin
							st_q  <= (command != CMD_NOP);
							pg_q  <= '0;
							ord_q <= '0;
						end
					end
				end
				S_DEC: begin
					if (cmd_q == CMD_ALLOC) begin
						if ({1'b0, ord_q} >= NORD) begin
							st_q    <= 1'b1;
							pg_q    <= '0;
							ord_q   <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= A_SCAN;
						end
					end else if ((cmd_q == CMD_FREE || cmd_q == CMD_ADD) && !st_q) begin
						state_q <= F_MRD;
					end else begin
						pg_q    <= '0;
						ord_q   <= '0;
						state_q <= S_FIN;
					end
				end
				A_SCAN: begin
					if (head_q[cur_q[HXW-1:0]] < NULL_LINK) begin
						pg_q    <= head_q[cur_q[HXW-1:0]][AW-1:0];
						tg_q    <= head_q[cur_q[HXW-1:0]][AW-1:0];
						lo_q    <= cur_q;
						ret_q   <= A_SPLIT;
						state_q <= UL_RD;
					end else if ({1'b0, cur_q} + (ORD_W+1)'(1) >= NORD) begin
						st_q    <= 1'b1;
						pg_q    <= '0;
						ord_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cur_q <= cur_q + ORD_W'(1);
					end
				end
				A_SPLIT: begin
					if (cur_q > ord_q) begin
						cur_q <= cur_n;
						if (b_split < POOL_B) begin
							lo_q    <= cur_n;
							tg_q    <= b_split[AW-1:0];
							pmark_q <= 1'b1;
							ret_q   <= A_SPLIT;
							state_q <= PU_RD;
						end
					end else begin
						state_q <= A_FRD;
					end
				end
				A_FRD: state_q <= A_FWR;
				A_FWR: state_q <= S_FIN;
				F_MRD: state_q <= F_MWR;
				F_MWR: begin
					if (cmd_q == CMD_FREE) begin
						state_q <= M_CHK;
					end else begin
						lo_q    <= ord_q;
						tg_q    <= pg_q;
						pmark_q <= 1'b0;
						ret_q   <= S_FIN;
						state_q <= PU_RD;
					end
				end
				M_CHK: begin
					if ({1'b0, ord_q} + (ORD_W+1)'(1) >= NORD || b_merge >= lim) begin
						lo_q    <= ord_q;
						tg_q    <= pg_q;
						pmark_q <= 1'b0;
						ret_q   <= S_FIN;
						state_q <= PU_RD;
					end else begin
						tg_q    <= b_merge[AW-1:0];
						state_q <= M_RD;
					end
				end
				M_RD: state_q <= M_EV;
				M_EV: begin
					if (r_free && r_ord == ord_q) begin
						lo_q    <= ord_q;
						ret_q   <= M_UP;
						state_q <= UL_RD;
					end else begin
						lo_q    <= ord_q;
						tg_q    <= pg_q;
						pmark_q <= 1'b0;
						ret_q   <= S_FIN;
						state_q <= PU_RD;
					end
				end
				M_UP: begin
					if (tg_q < pg_q) begin
						pg_q <= tg_q;
					end
					ord_q   <= ord_q + ORD_W'(1);
					state_q <= M_ORD;
				end
				M_ORD: state_q <= M_OWR;
				M_OWR: state_q <= M_CHK;
				UL_RD: state_q <= UL_GET;
				UL_GET: begin
					nx_q <= r_next;
					pv_q <= r_prev;
					if (r_prev < NULL_LINK) begin
						state_q <= UL_PVR;
					end else begin
						head_q[lo_q[HXW-1:0]] <= (r_next < NULL_LINK) ? r_next : NULL_LINK;
						state_q <= (r_next < NULL_LINK) ? UL_NXR : UL_PGR;
					end
				end
				UL_PVR: state_q <= UL_PVW;
				UL_PVW: state_q <= (nx_q < NULL_LINK) ? UL_NXR : UL_PGR;
				UL_NXR: state_q <= UL_NXW;
				UL_NXW: state_q <= UL_PGR;
				UL_PGR: state_q <= UL_PGW;
				UL_PGW: state_q <= ret_q;
				PU_RD: state_q <= PU_WR;
				PU_WR: begin
					nx_q                  <= head_lo;
					head_q[lo_q[HXW-1:0]] <= LW'(tg_q);
					state_q               <= (head_lo < NULL_LINK) ? PU_HR : ret_q;
				end
				PU_HR: state_q <= PU_HW;
				PU_HW: state_q <= ret_q;
				S_FIN: begin
					if (!out_valid || !out_stall) begin
						out_valid    <= 1'b1;
						status       <= st_q;
						result_index <= IDX_W'(pg_q);
						result_order <= ord_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (result_index == '0 && result_order == '0))
		else $error("rejected item carries a non-zero result");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |-> ({1'b0, result_order} < NORD))
		else $error("result order beyond the order count");
endmodule
`default_nettype wire
